@@ src/svl_pkg.sv @@
package svl_pkg;

    // Widths fixed by the item fields.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Default number of cells in the chain.
    localparam int DEPTH_DEF = 16;

    // Operation codes.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      write;
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ src/svl_cell.sv @@
module svl_cell (
    input  logic                               i_clk,
    input  svl_pkg::t_cell_ctl                 i_ctl,
    input  logic                               i_occupied,
    input  logic                               i_prev_lt,
    input  logic signed [svl_pkg::VALUE_W-1:0] i_prev_value,
    input  logic signed [svl_pkg::VALUE_W-1:0] i_next_value,
    output logic                               o_lt,
    output logic                               o_eq,
    output logic signed [svl_pkg::VALUE_W-1:0] o_value
);

    logic signed [svl_pkg::VALUE_W-1:0] r_value;
    logic signed [svl_pkg::VALUE_W-1:0] n_value;

    // Compare the held value against the broadcast value.
    assign o_lt    = i_occupied && (r_value < i_ctl.value);
    assign o_eq    = i_occupied && (r_value == i_ctl.value);
    assign o_value = r_value;

    // Cells at or after the boundary shift: right on insert, left on delete.
    // The first cell at the boundary takes the new value on insert.
    always_comb begin
        n_value = r_value;
        if (i_ctl.write && !o_lt) begin
            if (i_ctl.mode == svl_pkg::MODE_INSERT) begin
                n_value = i_prev_lt ? i_ctl.value : i_prev_value;
            end else begin
                n_value = i_next_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ src/sorted_value_list_core.sv @@
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------------
// in       | input     | i_in_valid / o_in_stall   | i_mode, i_item_value
// out      | output    | o_out_valid / i_out_stall | o_status, o_entry_count,
//          |           |                           | o_smallest_value
//
// Each transfer is processed by the chain of cells, one item per cycle while the input is not stalled.
// The result appears in the output register in the cycle after the input transfer.
// A new item is taken while the previous result is being transferred out.
// The input stalls only while a result waits in the output register under stall.
// Synchronous active-low reset empties the list; cell contents are not cleared.
module sorted_value_list_core #(
    parameter int DEPTH = svl_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic signed [svl_pkg::VALUE_W-1:0]  i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [svl_pkg::STATUS_W-1:0]        o_status,
    output logic [svl_pkg::COUNT_W-1:0]         o_entry_count,
    output logic signed [svl_pkg::VALUE_W-1:0]  o_smallest_value
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic                               r_out_valid;
    logic [svl_pkg::STATUS_W-1:0]       r_status;
    logic [svl_pkg::STATUS_W-1:0]       n_status;
    logic                               accept;
    logic                               full;
    logic                               found;
    svl_pkg::t_cell_ctl                 ctl;
    logic [DEPTH-1:0]                   cell_lt;
    logic [DEPTH-1:0]                   cell_eq;
    logic [DEPTH-1:0]                   cell_occ;
    logic signed [svl_pkg::VALUE_W-1:0] cell_value [DEPTH];

    // Input is held back only while a result is stuck in the output register.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign full  = (r_count == CW'(DEPTH));
    assign found = |cell_eq;

    // Command for the chain; a rejected insert or a missed delete writes nothing.
    always_comb begin
        ctl.mode  = i_mode;
        ctl.value = i_item_value;
        ctl.write = accept && ((i_mode == svl_pkg::MODE_INSERT) ? !full : found);
    end

    // Chain of cells, each linked to both neighbours.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                               prev_lt;
        logic signed [svl_pkg::VALUE_W-1:0] prev_value;
        logic signed [svl_pkg::VALUE_W-1:0] next_value;

        assign cell_occ[k] = (CW'(k) < r_count);

        if (k == 0) begin : g_head
            // The head has no predecessor, so the boundary may start here.
            assign prev_lt    = 1'b1;
            assign prev_value = cell_value[k];
        end else begin : g_body
            assign prev_lt    = cell_lt[k-1];
            assign prev_value = cell_value[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign next_value = cell_value[k];
        end else begin : g_inner
            assign next_value = cell_value[k+1];
        end

        svl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (cell_occ[k]),
            .i_prev_lt    (prev_lt),
            .i_prev_value (prev_value),
            .i_next_value (next_value),
            .o_lt         (cell_lt[k]),
            .o_eq         (cell_eq[k]),
            .o_value      (cell_value[k])
        );
    end

    // Next entry count and status of the item being taken.
    always_comb begin
        n_count  = r_count;
        n_status = svl_pkg::ST_DONE;
        if (i_mode == svl_pkg::MODE_INSERT) begin
            if (full) begin
                n_status = svl_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (found) begin
                n_count = r_count - CW'(1);
            end else begin
                n_status = svl_pkg::ST_ABSENT;
            end
        end
    end

    // Entry count and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    // The chain only moves on an input transfer, so the head is stable while a
    // result is held.
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_entry_count    = svl_pkg::COUNT_W'(r_count);
    assign o_smallest_value = (r_count != '0) ? cell_value[0] : '0;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A rejected insert leaves the count unchanged.
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_mode == svl_pkg::MODE_INSERT && full |=> r_count == $past(r_count))
        else $error("rejected insert changed the count");

    // A successful insert grows the list by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_mode == svl_pkg::MODE_INSERT && !full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list");

    // While the output is stalled, no new item enters the chain.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !accept)
        else $error("item taken over a held result");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import svl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_ITEMS = 1400;

    // One result as it leaves the block.
    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [COUNT_W-1:0]         count;
        logic signed [VALUE_W-1:0]  smallest;
    } t_list_result;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic                       op;
        logic signed [VALUE_W-1:0]  value;
        logic                       typed;
        t_list_result               res;
    } t_stim_row;

    localparam t_list_result NO_RES = '{ST_DONE, 5'd0, 32'sd0};

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_mode = MODE_INSERT;
    logic signed [VALUE_W-1:0]  i_item_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STATUS_W-1:0]        o_status;
    logic [COUNT_W-1:0]         o_entry_count;
    logic signed [VALUE_W-1:0]  o_smallest_value;

    // Shadow of the stored multiset, kept in ascending order.
    logic signed [VALUE_W-1:0]  held_values[$];
    t_list_result               pending_results[$];
    t_stim_row                  directed_rows[25];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  long_hold_req = 1'b0;

    sorted_value_list_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_item_value     (i_item_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_count    (o_entry_count),
        .o_smallest_value (o_smallest_value)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Applies one insert or delete to the shadow list and returns the result it gives.
    function automatic t_list_result apply_list_op(logic op, logic signed [VALUE_W-1:0] v);
        t_list_result r;
        int pos;
        pos = 0;
        r.status = ST_DONE;
        if (op == MODE_INSERT) begin
            if (held_values.size() >= DEPTH_DEF) begin
                r.status = ST_FULL;
            end else begin
                // A new value goes ahead of every equal value already held.
                while (pos < held_values.size() && held_values[pos] < v)
                    pos++;
                held_values.insert(pos, v);
            end
        end else begin
            while (pos < held_values.size() && held_values[pos] != v)
                pos++;
            if (pos >= held_values.size())
                r.status = ST_ABSENT;
            else
                held_values.delete(pos);
        end
        r.count = COUNT_W'(held_values.size());
        r.smallest = (held_values.size() > 0) ? held_values[0] : '0;
        return r;
    endfunction

    // Draws a value, often from a small cluster so that duplicates and hits are common.
    function automatic logic signed [VALUE_W-1:0] pick_value(bit for_delete);
        int sel;
        int t;
        if (for_delete && held_values.size() > 0 && $urandom_range(0, 9) < 7)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            t = int'($urandom_range(0, 16)) - 8;
            return t;
        end
        if (sel < 7) begin
            case ($urandom_range(0, 5))
                0: return 32'sh80000000;
                1: return 32'sh80000001;
                2: return 32'sh7FFFFFFF;
                3: return 32'sh7FFFFFFE;
                4: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    // Offers one item after a random gap and records its expected result on transfer.
    task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v,
                             input logic typed, input t_list_result typed_res);
        int gap;
        t_list_result predicted;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= op;
        i_item_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        predicted = apply_list_op(op, v);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Receiver: random stall before each result, and one long hold-off on request.
    initial begin : receiver
        int n;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 15);
                if (n != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Result checker: every output transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d count %0d smallest %0d",
                             o_status, o_entry_count, o_smallest_value);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_entry_count !== want.count ||
                    o_smallest_value !== want.smallest) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: expected status %0d count %0d smallest %0d, got status %0d count %0d smallest %0d",
                                 want.status, want.count, want.smallest,
                                 o_status, o_entry_count, o_smallest_value);
                end
            end
        end
    end

    initial begin : stimulus
        int ins_pct;
        logic op;

        // Directed part: empty store, extremes, new head, duplicates, head delete, full store.
        directed_rows = '{
            '{MODE_DELETE, 32'sd0,          1'b1, '{ST_ABSENT, 5'd0, 32'sd0}},
            '{MODE_INSERT, 32'sh7FFFFFFF,   1'b1, '{ST_DONE,   5'd1, 32'sh7FFFFFFF}},
            '{MODE_INSERT, 32'sh80000000,   1'b1, '{ST_DONE,   5'd2, 32'sh80000000}},
            '{MODE_INSERT, 32'sd0,          1'b1, '{ST_DONE,   5'd3, 32'sh80000000}},
            '{MODE_INSERT, 32'sd0,          1'b1, '{ST_DONE,   5'd4, 32'sh80000000}},
            '{MODE_INSERT, -32'sd1,         1'b1, '{ST_DONE,   5'd5, 32'sh80000000}},
            '{MODE_DELETE, 32'sh80000000,   1'b1, '{ST_DONE,   5'd4, -32'sd1}},
            '{MODE_DELETE, 32'sd5,          1'b1, '{ST_ABSENT, 5'd4, -32'sd1}},
            '{MODE_DELETE, 32'sd0,          1'b1, '{ST_DONE,   5'd3, -32'sd1}},
            '{MODE_INSERT, 32'sh80000001,   1'b0, NO_RES},
            '{MODE_INSERT, 32'sh7FFFFFFE,   1'b0, NO_RES},
            '{MODE_INSERT, 32'sh55555555,   1'b0, NO_RES},
            '{MODE_INSERT, 32'shAAAAAAAA,   1'b0, NO_RES},
            '{MODE_INSERT, 32'sd1,          1'b0, NO_RES},
            '{MODE_INSERT, -32'sd2,         1'b0, NO_RES},
            '{MODE_INSERT, 32'sd100,        1'b0, NO_RES},
            '{MODE_INSERT, -32'sd100,       1'b0, NO_RES},
            '{MODE_INSERT, 32'sh7FFFFFFF,   1'b0, NO_RES},
            '{MODE_INSERT, 32'sh80000000,   1'b0, NO_RES},
            '{MODE_INSERT, 32'sd3,          1'b0, NO_RES},
            '{MODE_INSERT, 32'sd3,          1'b0, NO_RES},
            '{MODE_INSERT, 32'sd2,          1'b0, NO_RES},
            '{MODE_INSERT, 32'sd0,          1'b1, '{ST_FULL,  5'd16, 32'sh80000000}},
            '{MODE_DELETE, 32'sh7FFFFFFF,   1'b0, NO_RES},
            '{MODE_DELETE, 32'sh80000000,   1'b0, NO_RES}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);

        // Random part: phases that fill, churn and drain the store, with idle-free bursts.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / 40) % 4)
                0: ins_pct = 85;
                2: ins_pct = 15;
                default: ins_pct = 50;
            endcase
            no_idle = ((n / 150) % 3) == 2;
            if (n == 300)
                long_hold_req = 1'b1;
            op = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_DELETE;
            send_item(op, pick_value(op == MODE_DELETE), 1'b0, NO_RES);
        end
        i_in_valid <= 1'b0;

        // Drain the remaining results, then allow a few more cycles for stray output.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
